// File: rtl/ukfq_pkg.sv
// Shared types and codes for the unique-key FIFO queue.
// Used by the storage cell, the top level and the port checker; no dependencies.
package ukfq_pkg;

   // Operation codes carried in the kind field.
   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   // Status codes reported with every result.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_DUP   = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_EMPTY = 2'd3;

   // Width of the reported occupancy field.
   localparam int OCC_W = 5;

   // One key and value pair as held in a cell.
   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] value;
   } pair_type;

   // Request transaction.
   typedef struct packed {
      logic               kind;
      logic signed [31:0] entry_key;
      logic signed [31:0] entry_value;
   } req_type;

   // Response transaction.
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_key;
      logic signed [31:0] out_value;
      logic [OCC_W-1:0]   occupancy;
      logic               is_empty;
   } rsp_type;

   // Per-cell control from the queue controller.
   typedef struct packed {
      logic held;      // cell holds a live pair
      logic shift_en;  // take the pair of the next younger cell
      logic load_en;   // take the enqueued pair
   } cell_ctrl_type;

endpackage

// File: rtl/ukfq_cell.sv
// One storage cell of the unique-key FIFO queue chain.
// Holds a pair, shifts toward the head on dequeue, compares its key. Uses ukfq_pkg.
module ukfq_cell
   import ukfq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  pair_type           new_pair,
   input  pair_type           next_pair,
   input  logic signed [31:0] cmp_key,
   output pair_type           pair,
   output logic               match
);

   pair_type pair_ff;
   pair_type pair_in;
   logic     match_ff;
   logic     match_in;

   // Pick the next content: neighbor on a shift, new pair on a load.
   always_comb begin
      pair_in = pair_ff;
      if (ctrl.shift_en) begin
         pair_in = next_pair;
      end else if (ctrl.load_en) begin
         pair_in = new_pair;
      end
   end

   // A live cell whose key equals the compared key flags a match.
   assign match_in = ctrl.held && (pair_ff.key == cmp_key);

   // Pair storage needs no reset; the held flag guards every read.
   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign pair  = pair_ff;
   assign match = match_ff;

endmodule

// File: rtl/unique_key_fifo_queue_unit.sv
// Unique-key FIFO queue built as a shifting chain of DEPTH cells.
// A request accepted in idle moves through the compare and commit states; the response
// strobe is registered out of commit. The cell key compare is registered during compare
// and used in commit; busy stays high through both, so no new request is taken until idle.
// Reset clears the occupancy count and the controller; the queue is empty at once.
// The response is shown for one cycle and the receiver cannot stall it.
module unique_key_fifo_queue_unit
   import ukfq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_COMPARE = 3'b010,
      ST_COMMIT  = 3'b100
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   req_type            req_ff;
   req_type            req_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   cell_ctrl_type      cell_ctrl [DEPTH];
   pair_type           cell_pair [DEPTH];
   pair_type           next_pair [DEPTH];
   logic [DEPTH-1:0]   cell_match;
   pair_type           enq_pair;

   logic               accept;
   logic               key_held;
   logic               queue_full;
   logic               enq_ok;
   logic               deq_ok;

   assign accept     = start && (state_ff == ST_IDLE);
   assign key_held   = |cell_match;
   assign queue_full = (count_ff == CNT_W'(DEPTH));
   assign enq_ok     = (state_ff == ST_COMMIT) && (req_ff.kind == KIND_ENQUEUE)
                       && !key_held && !queue_full;
   assign deq_ok     = (state_ff == ST_COMMIT) && (req_ff.kind == KIND_DEQUEUE)
                       && (count_ff != '0);

   assign enq_pair.key   = req_ff.entry_key;
   assign enq_pair.value = req_ff.entry_value;

   // Controller: accept, let the cells compare, then commit.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Capture the request transaction on accept.
   assign req_in = accept ? req_item : req_ff;

   // Occupancy update on a successful enqueue or dequeue.
   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (deq_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Build the response transaction during commit.
   always_comb begin
      rsp_in           = rsp_ff;
      rsp_valid_in     = (state_ff == ST_COMMIT);
      if (state_ff == ST_COMMIT) begin
         rsp_in.out_key   = '0;
         rsp_in.out_value = '0;
         if (req_ff.kind == KIND_ENQUEUE) begin
            if (key_held) begin
               rsp_in.status = STATUS_DUP;
            end else if (queue_full) begin
               rsp_in.status = STATUS_FULL;
            end else begin
               rsp_in.status = STATUS_OK;
            end
         end else begin
            if (count_ff == '0) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.status    = STATUS_OK;
               rsp_in.out_key   = cell_pair[0].key;
               rsp_in.out_value = cell_pair[0].value;
            end
         end
         rsp_in.occupancy = OCC_W'(count_in);
         rsp_in.is_empty  = (count_in == '0);
      end
   end

   // The cell chain; the youngest end shifts in an empty pair.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_last
         assign next_pair[i] = '0;
      end else begin : g_inner
         assign next_pair[i] = cell_pair[i+1];
      end

      assign cell_ctrl[i].held     = (count_ff > CNT_W'(i));
      assign cell_ctrl[i].shift_en = deq_ok;
      assign cell_ctrl[i].load_en  = enq_ok && (count_ff == CNT_W'(i));

      ukfq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl[i]),
         .new_pair  (enq_pair),
         .next_pair (next_pair[i]),
         .cmp_key   (req_ff.entry_key),
         .pair      (cell_pair[i]),
         .match     (cell_match[i])
      );
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: rtl/ukfq_checker.sv
// Port-level checker for the unique-key FIFO queue, bound to the top level.
// Depends on ukfq_pkg and unique_key_fifo_queue_unit.
module ukfq_checker
   import ukfq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // An accepted transaction makes the unit busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after an accepted transaction");

   // Every accepted transaction gets its response.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("response missing three cycles after accept");

   // Responses never come back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // The empty flag agrees with the occupancy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.is_empty == (rsp_item.occupancy == '0)))
      else $error("empty flag disagrees with occupancy");

   // A rejected transaction returns no pair.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status == STATUS_DUP || rsp_item.status == STATUS_FULL
                     || rsp_item.status == STATUS_EMPTY))
      |-> (rsp_item.out_key == '0 && rsp_item.out_value == '0))
      else $error("rejected transaction returned a pair");

endmodule

bind unique_key_fifo_queue_unit ukfq_checker u_ukfq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

// File: bench/tb_top.sv
// Self-checking testbench for the unique-key FIFO queue: directed table, then random traffic.
// Depends on ukfq_pkg and unique_key_fifo_queue_unit; compares every response to a typed row or a local model.
`timescale 1ns / 1ps

module tb_top;
   import ukfq_pkg::*;

   localparam int DEPTH          = 16;
   localparam int RANDOM_ITEMS   = 850;
   localparam int IDLE_LIMIT     = 500;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PRINT_LIMIT    = 40;

   logic    clock      = 1'b0;
   logic    reset      = 1'b1;
   logic    start      = 1'b0;
   req_type req_item   = '0;
   logic    busy;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Expectation for the transaction on the request port when the row gives one.
   logic    row_typed  = 1'b0;
   rsp_type row_expect = '0;

   // Local copy of the queue contents.
   logic [31:0] mirror_key [DEPTH];
   logic [31:0] mirror_value [DEPTH];
   int          mirror_head = 0;
   int          mirror_tail = 0;
   int          mirror_count = 0;

   rsp_type pending_results[$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;

   // Directed stimulus table.
   req_type dir_req[$];
   rsp_type dir_rsp[$];
   bit      dir_typed[$];

   logic [31:0] key_pool [24];

   unique_key_fifo_queue_unit #(.DEPTH(DEPTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // Applies one transaction to the local queue and returns the response it should give.
   function automatic rsp_type queue_step(input req_type r);
      rsp_type res;
      bit      held;
      int      pos;
      res = '0;
      if (r.kind == KIND_ENQUEUE) begin
         held = 1'b0;
         pos = mirror_head;
         for (int n = 0; n < mirror_count; n++) begin
            if (mirror_key[pos] == r.entry_key) begin
               held = 1'b1;
            end
            pos = (pos + 1) % DEPTH;
         end
         if (held) begin
            res.status = STATUS_DUP;
         end else if (mirror_count >= DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            mirror_key[mirror_tail] = r.entry_key;
            mirror_value[mirror_tail] = r.entry_value;
            mirror_tail = (mirror_tail + 1) % DEPTH;
            mirror_count++;
            res.status = STATUS_OK;
         end
      end else begin
         if (mirror_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.out_key = mirror_key[mirror_head];
            res.out_value = mirror_value[mirror_head];
            mirror_head = (mirror_head + 1) % DEPTH;
            mirror_count--;
            res.status = STATUS_OK;
         end
      end
      res.occupancy = mirror_count[OCC_W-1:0];
      res.is_empty = (mirror_count == 0);
      return res;
   endfunction

   // Prints one mismatch line, up to a cap, and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
      end
   endtask

   // Accepts request transactions, records expectations and checks responses.
   always @(posedge clock) begin : monitor
      rsp_type want;
      rsp_type predicted;
      bit      active;
      if (!reset) begin
         active = 1'b0;
         if (start && !busy) begin
            predicted = queue_step(req_item);
            pending_results.push_back(row_typed ? row_expect : predicted);
            active = 1'b1;
         end
         if (rsp_valid) begin
            active = 1'b1;
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected response", rsp_item.out_key, 32'h0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_item.status !== want.status)
                  report_mismatch("status", 32'(rsp_item.status), 32'(want.status));
               if (rsp_item.out_key !== want.out_key)
                  report_mismatch("out_key", rsp_item.out_key, want.out_key);
               if (rsp_item.out_value !== want.out_value)
                  report_mismatch("out_value", rsp_item.out_value, want.out_value);
               if (rsp_item.occupancy !== want.occupancy)
                  report_mismatch("occupancy", 32'(rsp_item.occupancy),
                                  32'(want.occupancy));
               if (rsp_item.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_item.is_empty),
                                  32'(want.is_empty));
            end
         end
         // Nothing moved on either side for too long: the block has hung.
         idle_cycles = active ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("unique_key_fifo_queue_unit verification failed");
            $finish;
         end
      end
   end

   // Drives one transaction from a falling edge and returns at the falling edge after it is taken.
   task automatic issue(input req_type r, input bit has_typed, input rsp_type typed_rsp);
      req_item <= r;
      start <= 1'b1;
      row_typed <= has_typed;
      row_expect <= typed_rsp;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic add_row(input logic kind, input logic [31:0] k, input logic [31:0] v,
                          input bit has_typed, input rsp_type typed_rsp);
      dir_req.push_back(req_type'{kind, k, v});
      dir_typed.push_back(has_typed);
      dir_rsp.push_back(typed_rsp);
   endtask

   // Chooses a key: often from a small pool so duplicates happen, sometimes a held key.
   function automatic logic [31:0] pick_key();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 15 && mirror_count > 0)
         return mirror_key[(mirror_head + $urandom_range(0, mirror_count - 1)) % DEPTH];
      else if (sel < 65)
         return key_pool[$urandom_range(0, 23)];
      else
         return $urandom;
   endfunction

   initial begin : stimulus
      int      burst_left;
      int      enq_bias;
      req_type r;
      logic [31:0] fk;

      // Known extremes in the pool, the rest random.
      for (int i = 0; i < 24; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      key_pool[2] = 32'h8000_0000;
      key_pool[3] = 32'h7FFF_FFFF;

      // Empty, extremes of key and value, duplicate, drain, then fill to full.
      add_row(KIND_DEQUEUE, 32'h0, 32'h0, 1'b1,
              rsp_type'{STATUS_EMPTY, 32'sh0, 32'sh0, 5'd0, 1'b1});
      add_row(KIND_ENQUEUE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
              rsp_type'{STATUS_OK, 32'sh0, 32'sh0, 5'd1, 1'b0});
      add_row(KIND_ENQUEUE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
              rsp_type'{STATUS_OK, 32'sh0, 32'sh0, 5'd2, 1'b0});
      add_row(KIND_ENQUEUE, 32'h8000_0000, 32'h0000_0001, 1'b1,
              rsp_type'{STATUS_DUP, 32'sh0, 32'sh0, 5'd2, 1'b0});
      add_row(KIND_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              rsp_type'{STATUS_OK, 32'sh8000_0000, 32'sh7FFF_FFFF, 5'd1, 1'b0});
      add_row(KIND_DEQUEUE, 32'h0, 32'h0, 1'b1,
              rsp_type'{STATUS_OK, 32'sh7FFF_FFFF, 32'sh8000_0000, 5'd0, 1'b1});
      add_row(KIND_DEQUEUE, 32'h0, 32'h0, 1'b1,
              rsp_type'{STATUS_EMPTY, 32'sh0, 32'sh0, 5'd0, 1'b1});
      // Sixteen distinct keys from zero to all ones; the indices wrap on the way.
      for (int i = 0; i < DEPTH; i++) begin
         fk = i * 32'h1111_1111;
         add_row(KIND_ENQUEUE, fk, ~fk, 1'b0, '0);
      end
      add_row(KIND_ENQUEUE, 32'h1234_5678, 32'h0, 1'b1,
              rsp_type'{STATUS_FULL, 32'sh0, 32'sh0, 5'd16, 1'b0});
      // A held key on a full queue reports the duplicate, not the full status.
      add_row(KIND_ENQUEUE, 32'h7777_7777, 32'h0, 1'b1,
              rsp_type'{STATUS_DUP, 32'sh0, 32'sh0, 5'd16, 1'b0});

      // Hold reset, then release it on a falling edge.
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      burst_left = $urandom_range(1, 12);
      enq_bias = 50;
      for (int i = 0; i < dir_req.size() + RANDOM_ITEMS; i++) begin
         if (i < dir_req.size()) begin
            issue(dir_req[i], dir_typed[i], dir_rsp[i]);
         end else begin
            // Shift the enqueue share now and then so the queue swings between full and empty.
            if ((i % 30) == 0) begin
               case ($urandom_range(0, 2))
                  0: enq_bias = 20;
                  1: enq_bias = 50;
                  default: enq_bias = 85;
               endcase
            end
            r.kind = ($urandom_range(0, 99) < enq_bias) ? KIND_ENQUEUE : KIND_DEQUEUE;
            r.entry_key = pick_key();
            r.entry_value = $urandom;
            issue(r, 1'b0, '0);
         end
         // Bursts of back-to-back requests separated by random gaps.
         burst_left--;
         if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
         end
      end
      start <= 1'b0;

      // Let every outstanding response arrive, then watch for strays.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("unique_key_fifo_queue_unit verification clean");
      end else begin
         $display("unique_key_fifo_queue_unit verification failed");
      end
      $finish;
   end

endmodule
